// ----- hdl/atmf_pkg.sv -----
// Package for the ARGB8888 to mask-format pixel packer.
// Holds widths, register indexes, reset masks and the mask decode functions.
// No dependencies.
`default_nettype none

package atmf_pkg;

	// Widths of the pixel, of one channel and of the shift and drop amounts.
	localparam int PIXEL_W  = 32;
	localparam int CHAN_W   = 8;
	localparam int NUM_CHAN = 4;
	localparam int SHIFT_W  = $clog2(PIXEL_W);
	localparam int DROP_W   = $clog2(CHAN_W + 1);
	localparam int SPAN_W   = $clog2(PIXEL_W + 1);
	localparam int CHAN_IDX_W = $clog2(NUM_CHAN);
	localparam int REG_IDX_W  = 3;

	typedef logic [PIXEL_W-1:0] pixel_t;
	typedef logic [CHAN_W-1:0]  chan_t;
	typedef logic [SHIFT_W-1:0] shift_t;
	typedef logic [DROP_W-1:0]  drop_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	// Register indexes; channel registers share their index with the channel number.
	localparam reg_idx_t REG_RED   = 3'd0;
	localparam reg_idx_t REG_GREEN = 3'd1;
	localparam reg_idx_t REG_BLUE  = 3'd2;
	localparam reg_idx_t REG_ALPHA = 3'd3;
	localparam reg_idx_t REG_WIDE  = 3'd4;

	// Reset masks, in channel order red, green, blue, alpha.
	localparam pixel_t MASK_RESET [NUM_CHAN] = '{
		32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'hFF00_0000
	};

	// Position of each channel inside the ARGB8888 source pixel.
	localparam int CHAN_LSB [NUM_CHAN] = '{16, 8, 0, 24};

	// Trailing zero count of a mask; zero for an empty mask.
	function automatic shift_t mask_lsb(input pixel_t m);
		shift_t lo;
		lo = '0;
		for (int i = PIXEL_W - 1; i >= 0; i--) begin
			if (m[i]) begin
				lo = shift_t'(i);
			end
		end
		return lo;
	endfunction

	// Index of the highest set bit of a mask; zero for an empty mask.
	function automatic shift_t mask_msb(input pixel_t m);
		shift_t hi;
		hi = '0;
		for (int i = 0; i < PIXEL_W; i++) begin
			if (m[i]) begin
				hi = shift_t'(i);
			end
		end
		return hi;
	endfunction

	// Right drop applied to the 8-bit channel: eight minus the span, never negative.
	// An empty mask drops all eight bits.
	function automatic drop_t mask_drop(input pixel_t m);
		logic [SPAN_W-1:0] span;
		drop_t drop;
		span = SPAN_W'(mask_msb(m)) - SPAN_W'(mask_lsb(m)) + SPAN_W'(1);
		if (m == '0) begin
			drop = drop_t'(CHAN_W);
		end else if (span >= SPAN_W'(CHAN_W)) begin
			drop = '0;
		end else begin
			drop = drop_t'(SPAN_W'(CHAN_W) - span);
		end
		return drop;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/argb_to_mask_format_packer.sv -----
// Top level of the ARGB8888 to mask-format pixel packer: configuration registers
// and a four-stage conversion pipeline. Depends on atmf_pkg.
`default_nettype none

// The block converts one ARGB8888 pixel per clock, unless the output stalls, into
// an output format set by four channel masks and a 16/32-bit width bit. Throughput
// is one word per cycle without a stall. A word accepted into stage 1 moves through
// stages 2 and 3 and is offered from stage 4. The four pipeline stages (channel
// reduce, place and mask, pair add, final add) each hold one word and advance
// independently, so a stall on the output only fills the bubbles behind it. Shift
// amounts are decoded from the write data when a mask register is written, so the
// masks cost nothing per pixel. Write the registers only while no word is in flight.
module argb_to_mask_format_packer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [atmf_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [atmf_pkg::PIXEL_W-1:0]   cfg_data,
	input  wire logic                           source_valid,
	output logic                                source_ready,
	input  wire logic [atmf_pkg::PIXEL_W-1:0]   source_pixel,
	output logic                                packed_valid,
	input  wire logic                           packed_ready,
	output logic [atmf_pkg::PIXEL_W-1:0]        packed_pixel
);

	atmf_pkg::pixel_t mask_q   [atmf_pkg::NUM_CHAN];
	atmf_pkg::shift_t rshift_q [atmf_pkg::NUM_CHAN];
	atmf_pkg::drop_t  drop_q   [atmf_pkg::NUM_CHAN];
	logic             wide_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	atmf_pkg::chan_t  chan_s1  [atmf_pkg::NUM_CHAN];
	atmf_pkg::pixel_t placed_s2 [atmf_pkg::NUM_CHAN];
	atmf_pkg::pixel_t pair_s3  [2];
	atmf_pkg::pixel_t sum_s4;

	// Configuration registers; shift and drop are decoded from the write data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < atmf_pkg::NUM_CHAN; i++) begin
				mask_q[i]   <= atmf_pkg::MASK_RESET[i];
				rshift_q[i] <= atmf_pkg::mask_lsb(atmf_pkg::MASK_RESET[i]);
				drop_q[i]   <= atmf_pkg::mask_drop(atmf_pkg::MASK_RESET[i]);
			end
			wide_q <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index) inside
				atmf_pkg::REG_RED, atmf_pkg::REG_GREEN,
				atmf_pkg::REG_BLUE, atmf_pkg::REG_ALPHA: begin
					mask_q[cfg_index[atmf_pkg::CHAN_IDX_W-1:0]]   <= cfg_data;
					rshift_q[cfg_index[atmf_pkg::CHAN_IDX_W-1:0]] <=
						atmf_pkg::mask_lsb(cfg_data);
					drop_q[cfg_index[atmf_pkg::CHAN_IDX_W-1:0]]   <=
						atmf_pkg::mask_drop(cfg_data);
				end
				atmf_pkg::REG_WIDE: begin
					wide_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Each stage advances when it is empty or the stage after it advances.
	assign adv_s4       = !valid_s4 || packed_ready;
	assign adv_s3       = !valid_s3 || adv_s4;
	assign adv_s2       = !valid_s2 || adv_s3;
	assign adv_s1       = !valid_s1 || adv_s2;
	assign source_ready = adv_s1;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= source_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
			if (adv_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// Stage 1: split the pixel and reduce each channel by its drop.
	always_ff @(posedge clk) begin
		if (adv_s1 && source_valid) begin
			for (int i = 0; i < atmf_pkg::NUM_CHAN; i++) begin
				chan_s1[i] <= source_pixel[atmf_pkg::CHAN_LSB[i] +: atmf_pkg::CHAN_W]
					>> drop_q[i];
			end
		end
	end

	// Stage 2: shift each channel into place; bits past the top fall off, then mask.
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			for (int i = 0; i < atmf_pkg::NUM_CHAN; i++) begin
				placed_s2[i] <= (atmf_pkg::PIXEL_W'(chan_s1[i]) << rshift_q[i])
					& mask_q[i];
			end
		end
	end

	// Stage 3: add the parts in pairs; overlapping masks carry, modulo 2^32.
	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			pair_s3[0] <= placed_s2[0] + placed_s2[1];
			pair_s3[1] <= placed_s2[2] + placed_s2[3];
		end
	end

	// Stage 4: final sum, cut to 16 bits in narrow mode.
	always_ff @(posedge clk) begin
		if (adv_s4 && valid_s3) begin
			if (wide_q) begin
				sum_s4 <= pair_s3[0] + pair_s3[1];
			end else begin
				sum_s4 <= {{(atmf_pkg::PIXEL_W/2){1'b0}},
					pair_s3[0][atmf_pkg::PIXEL_W/2-1:0] + pair_s3[1][atmf_pkg::PIXEL_W/2-1:0]};
			end
		end
	end

	assign packed_valid = valid_s4;
	assign packed_pixel = sum_s4;

`ifndef SYNTHESIS
	// Narrow mode never shows upper bits.
	a_narrow_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		packed_valid && !wide_q |-> packed_pixel[atmf_pkg::PIXEL_W-1:atmf_pkg::PIXEL_W/2] == '0)
		else $error("upper half set in 16-bit mode");

	// Backpressure on the input only when every stage holds a word.
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!source_ready |-> valid_s1 && valid_s2 && valid_s3 && valid_s4)
		else $error("input stalled with an empty stage");

	// A stalled stage 2 keeps its word.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !adv_s3 |=> valid_s2 && $stable(placed_s2[0]))
		else $error("stage 2 word lost under stall");

	// Decoded drops never exceed the channel width.
	a_drop_range: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q[0] <= atmf_pkg::DROP_W'(atmf_pkg::CHAN_W)
		&& drop_q[1] <= atmf_pkg::DROP_W'(atmf_pkg::CHAN_W)
		&& drop_q[2] <= atmf_pkg::DROP_W'(atmf_pkg::CHAN_W)
		&& drop_q[3] <= atmf_pkg::DROP_W'(atmf_pkg::CHAN_W))
		else $error("channel drop out of range");
`endif

endmodule

`default_nettype wire
